// ----- rtl/core/r250_pkg.sv -----
// Shared constants and codes for the R250 XOR shift generator.
`default_nettype none

package r250_pkg;

    localparam int IDX_W       = 8;
    localparam int DATA_W      = 32;
    localparam int MAX_WORD_W  = 64;
    localparam int STORE_DEPTH = 250;
    localparam int LAG_FWD     = 103;

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(STORE_DEPTH - 1);

    localparam logic [1:0] MODE_LOAD        = 2'd0;
    localparam logic [1:0] MODE_GENERATE    = 2'd1;
    localparam logic [1:0] MODE_SET_POINTER = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/r250_cell.sv -----
// One storage cell of the R250 ring: load from the port or take the right neighbour.
`default_nettype none

module r250_cell #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             shift_en,
    input  logic             load_en,
    input  logic [WIDTH-1:0] shift_in,
    input  logic [WIDTH-1:0] load_word,
    output logic [WIDTH-1:0] word_q
);

    logic [WIDTH-1:0] word_reg;
    logic [WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (load_en)
        begin
            word_next = load_word;
        end
        else if (shift_en)
        begin
            word_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_q = word_reg;

endmodule

`default_nettype wire

// ----- rtl/core/r250_xor_shift_generator.sv -----
// Top level of the R250 XOR shift generator: ring of cells, pointer and output stage.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+--------------------------------------
//  in      | into blk  | in_valid/in_stall  | mode, target_index, seed_word
//  out     | from blk  | out_valid/out_stall| random_value, next_pointer
//
// Load and generate beats may follow back to back while in_stall is low.
// A generate beat shows its result on the cycle after acceptance if main is free.
// A set-pointer beat rotates the ring one cell a cycle until the new pointer
// sits at cell 0, with in_stall held high meanwhile.
// Output has a main register and a skid register; in_stall rises only when
// both are full or a rotation is running.
// Reset clears the pointer, the busy flag and the output valids; cell contents
// are undefined until loaded.
`default_nettype none

module r250_xor_shift_generator #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [r250_pkg::IDX_W-1:0]  target_index,
    input  logic [r250_pkg::DATA_W-1:0] seed_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [r250_pkg::DATA_W-1:0] random_value,
    output logic [r250_pkg::IDX_W-1:0]  next_pointer
);

    import r250_pkg::*;

    // Cell k always holds logical entry (ptr + k) mod 250, so the two taps of
    // a generate are fixed at cell 0 and cell 103 (the word 147 behind p).
    logic [WORD_WIDTH-1:0] cell_q [STORE_DEPTH];
    logic [WORD_WIDTH-1:0] ring_in;
    logic [WORD_WIDTH-1:0] gen_word;
    logic [WORD_WIDTH-1:0] load_word;
    logic [MAX_WORD_W-1:0] seed_wide;
    logic [MAX_WORD_W-1:0] gen_wide;

    logic in_fire;
    logic gen_fire;
    logic load_fire;
    logic set_fire;
    logic idx_ok;
    logic shift_en;

    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic [IDX_W-1:0] ptr_adv;
    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] target_reg;
    logic [IDX_W-1:0] target_next;

    logic [IDX_W:0]   slot_diff;
    logic [IDX_W:0]   slot_wrap;
    logic [IDX_W-1:0] load_slot;

    // Output stage
    logic                main_valid_reg;
    logic                main_valid_next;
    logic [DATA_W-1:0]   main_val_reg;
    logic [DATA_W-1:0]   main_val_next;
    logic [IDX_W-1:0]    main_ptr_reg;
    logic [IDX_W-1:0]    main_ptr_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic [DATA_W-1:0]   skid_val_reg;
    logic [DATA_W-1:0]   skid_val_next;
    logic [IDX_W-1:0]    skid_ptr_reg;
    logic [IDX_W-1:0]    skid_ptr_next;
    logic                pop;
    logic [DATA_W-1:0]   res_val;

    // ---------------------------------------------------------------- input
    assign in_stall = skid_valid_reg || busy_reg;
    assign in_fire  = in_valid && !in_stall;
    assign idx_ok   = (target_index <= LAST_INDEX);

    always_comb
    begin
        gen_fire  = 1'b0;
        load_fire = 1'b0;
        set_fire  = 1'b0;
        case (mode)
            MODE_LOAD:        load_fire = in_fire && idx_ok;
            MODE_GENERATE:    gen_fire  = in_fire;
            MODE_SET_POINTER: set_fire  = in_fire && idx_ok;
            default:
            begin
                gen_fire  = 1'b0;
            end
        endcase
    end

    // Physical cell of a load: (index - ptr) mod 250
    assign slot_diff = {1'b0, target_index} - {1'b0, ptr_reg};
    assign slot_wrap = slot_diff + (IDX_W+1)'(STORE_DEPTH);
    assign load_slot = slot_diff[IDX_W] ? slot_wrap[IDX_W-1:0] : slot_diff[IDX_W-1:0];

    assign seed_wide = MAX_WORD_W'(seed_word);
    assign load_word = seed_wide[WORD_WIDTH-1:0];

    // ----------------------------------------------------------------- ring
    // Generate: the new word re-enters at the tail as the ring steps by one.
    // Rotation: the head word goes round unchanged.
    assign gen_word = cell_q[0] ^ cell_q[LAG_FWD];
    assign ring_in  = busy_reg ? cell_q[0] : gen_word;
    assign shift_en = gen_fire || busy_reg;

    for (genvar k = 0; k < STORE_DEPTH; k++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] nbr;
        if (k == STORE_DEPTH - 1)
        begin : g_tail
            assign nbr = ring_in;
        end
        else
        begin : g_body
            assign nbr = cell_q[k+1];
        end

        r250_cell #(
            .WIDTH (WORD_WIDTH)
        ) u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .load_en   (load_fire && (load_slot == IDX_W'(k))),
            .shift_in  (nbr),
            .load_word (load_word),
            .word_q    (cell_q[k])
        );
    end

    // -------------------------------------------------------------- pointer
    assign ptr_adv = (ptr_reg == LAST_INDEX) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        ptr_next    = shift_en ? ptr_adv : ptr_reg;
        target_next = set_fire ? target_index : target_reg;
        if (busy_reg)
        begin
            busy_next = (ptr_adv != target_reg);
        end
        else
        begin
            busy_next = set_fire && (target_index != ptr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
    end

    // --------------------------------------------------------- output stage
    assign gen_wide = MAX_WORD_W'(gen_word);
    assign res_val  = gen_wide[DATA_W-1:0];
    assign pop      = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_val_next   = main_val_reg;
        main_ptr_next   = main_ptr_reg;
        skid_valid_next = skid_valid_reg;
        skid_val_next   = skid_val_reg;
        skid_ptr_next   = skid_ptr_reg;
        if (main_valid_reg && !pop)
        begin
            // main held: a new beat parks in the skid (empty, else stalled)
            if (gen_fire)
            begin
                skid_valid_next = 1'b1;
                skid_val_next   = res_val;
                skid_ptr_next   = ptr_adv;
            end
        end
        else if (skid_valid_reg)
        begin
            main_valid_next = 1'b1;
            main_val_next   = skid_val_reg;
            main_ptr_next   = skid_ptr_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            main_valid_next = gen_fire;
            if (gen_fire)
            begin
                main_val_next = res_val;
                main_ptr_next = ptr_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_val_reg <= main_val_next;
        main_ptr_reg <= main_ptr_next;
        skid_val_reg <= skid_val_next;
        skid_ptr_reg <= skid_ptr_next;
    end

    assign out_valid    = main_valid_reg;
    assign random_value = main_val_reg;
    assign next_pointer = main_ptr_reg;

endmodule

`default_nettype wire

// ----- rtl/core/r250_checker.sv -----
// Port-level checks for the R250 generator, bound to the top level.
`default_nettype none

module r250_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  mode,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [r250_pkg::DATA_W-1:0] random_value,
    input logic [r250_pkg::IDX_W-1:0]  next_pointer
);

    import r250_pkg::*;

    // Held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(random_value)
            && $stable(next_pointer))
        else $error("output beat changed while stalled");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_pointer <= LAST_INDEX)
        else $error("next_pointer out of range");

    // A generate into an empty output shows a beat next cycle
    a_gen_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == MODE_GENERATE && !out_valid |=> out_valid)
        else $error("generate beat produced no result");

    // Load, set-pointer and unused codes create no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode != MODE_GENERATE && !out_valid |=> !out_valid)
        else $error("result without a generate beat");

endmodule

bind r250_xor_shift_generator r250_checker u_r250_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value),
    .next_pointer (next_pointer)
);

`default_nettype wire
